// ----- rtl/directory_cache_tag_table_unit_defines.svh -----
// Shared assertion macros
`ifndef DIRECTORY_CACHE_TAG_TABLE_UNIT_DEFINES_SVH
`define DIRECTORY_CACHE_TAG_TABLE_UNIT_DEFINES_SVH

// Assert a property on the rising clock edge outside reset
`define DCTT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assert that a condition implies another in the following cycle
`define DCTT_ASSERT_NEXT(lbl, clk, rstn, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) else $error(msg);

`endif

// ----- rtl/dctt_pkg.sv -----
package dctt_pkg;

  localparam int unsigned Entries  = 64;
  localparam int unsigned IdxW     = 6;
  localparam int unsigned CntW     = 7;
  localparam int unsigned Devices  = 16;
  localparam int unsigned EvictShare = 3;
  localparam int unsigned PhaseLimit = 10;

  localparam logic [2:0] OpLookup   = 3'd0;
  localparam logic [2:0] OpTouch    = 3'd1;
  localparam logic [2:0] OpInvDev   = 3'd2;
  localparam logic [2:0] OpInvEntry = 3'd3;
  localparam logic [2:0] OpDirty    = 3'd4;
  localparam logic [2:0] OpFlush    = 3'd5;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StBadDev  = 2'd1;
  localparam logic [1:0] StFull    = 2'd2;

  localparam logic [0:0] RegMask = 1'b0;
  localparam logic [0:0] RegCap  = 1'b1;

  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  device;
    logic [31:0] block;
    logic [1:0]  entry_type;
  } req_t;

  typedef struct packed {
    logic            hit;
    logic [IdxW-1:0] index;
    logic            allocated;
    logic [1:0]      status;
    logic [CntW-1:0] count;
  } rsp_t;

endpackage

// ----- rtl/directory_cache_tag_table_unit.sv -----
// Directory cache tag table.
// Request channel: req_valid_i/req_ready_o carry one request word (op, device,
// block, entry_type). Response channel: rsp_valid_o/rsp_ready_i return one
// word (hit, index, allocated, status, count) per request.
// Configuration: APB-style port, register 0 device mask, register 1 capacity.
// Requests are handled one at a time by a sequencer that walks the tag store
// one entry per cycle with a single compare unit. Lookup, mark dirty and
// invalidate entry scan the entries in use until a match; invalidate device
// and flush scan all entries in use; a touch miss runs up to ten eviction
// passes over the entries in use, each after a free-slot scan of them.
// The tag store is a memory read one entry per cycle with registered data.
// At reset entries_in_use and roll clear, so no entry is visible; the store
// itself needs no clearing. A stalled response holds in the output register
// and no new request is taken until it is collected.
module directory_cache_tag_table_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  dctt_pkg::req_t req_i,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  output dctt_pkg::rsp_t rsp_o,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  localparam int unsigned IW = dctt_pkg::IdxW;
  localparam int unsigned CW = dctt_pkg::CntW;

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SScan  = 4'd1;
  localparam logic [3:0] SFree  = 4'd2;
  localparam logic [3:0] SEvict = 4'd3;
  localparam logic [3:0] SGrow  = 4'd4;
  localparam logic [3:0] SOut   = 4'd5;

  logic [15:0] mask_q;
  logic [CW-1:0] cap_q;
  logic [3:0] st_q, st_d;
  dctt_pkg::req_t r_q;
  logic [CW-1:0] used_cnt_q, used_cnt_d;
  logic [1:0] roll_q, roll_d;
  logic [3:0] phase_q, phase_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] need_q, need_d;
  dctt_pkg::rsp_t rsp_q, rsp_d;
  logic rv_q, rv_d;

  logic [63:0] used_m, dirty_m;
  logic [3:0]  dev_m  [dctt_pkg::Entries];
  logic [31:0] blk_m  [dctt_pkg::Entries];
  logic [1:0]  kind_m [dctt_pkg::Entries];
  logic [3:0]  rd_dev_q;
  logic [31:0] rd_blk_q;
  logic [1:0]  rd_kind_q;
  logic        rd_used_q, rd_dirty_q, rd_ok_q;
  logic [IW-1:0] rd_idx_q;

  logic        clr_used, set_dirty, clr_dirty, wr_tag;
  logic [IW-1:0] wr_idx;

  logic accept, cfg_wr, dev_ok, rd_en;
  logic tag_eq, kind_eq;
  logic [CW-1:0] cap_eff;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_comb begin
    prdata = '0;
    if (paddr[2] == dctt_pkg::RegCap) prdata = {25'd0, cap_q};
    else prdata = {16'd0, mask_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= 16'hFFFF;
      cap_q  <= 7'd64;
    end else if (cfg_wr) begin
      if (paddr[2] == dctt_pkg::RegMask) mask_q <= pwdata[15:0];
      else cap_q <= pwdata[6:0];
    end
  end

  assign req_ready_o = (st_q == SIdle) && !rv_q;
  assign accept      = req_valid_i && req_ready_o;
  assign rsp_valid_o = rv_q;
  assign rsp_o       = rsp_q;
  assign cap_eff     = (cap_q > CW'(dctt_pkg::Entries)) ? CW'(dctt_pkg::Entries) : cap_q;
  assign dev_ok      = mask_q[r_q.device];

  // one-entry-per-cycle read of the tag store
  assign rd_en = (ptr_q < used_cnt_q);
  always_ff @(posedge clk_i) begin
    rd_dev_q  <= dev_m[ptr_q[IW-1:0]];
    rd_blk_q  <= blk_m[ptr_q[IW-1:0]];
    rd_kind_q <= kind_m[ptr_q[IW-1:0]];
    rd_used_q <= used_m[ptr_q[IW-1:0]];
    rd_dirty_q <= dirty_m[ptr_q[IW-1:0]];
    rd_idx_q  <= ptr_q[IW-1:0];
    if (wr_tag) begin
      dev_m[wr_idx]  <= r_q.device;
      blk_m[wr_idx]  <= r_q.block;
      kind_m[wr_idx] <= r_q.entry_type;
    end
    if (clr_used) used_m[wr_idx] <= 1'b0;
    if (wr_tag) used_m[wr_idx] <= 1'b1;
    if (set_dirty) dirty_m[wr_idx] <= 1'b1;
    if (clr_dirty || wr_tag) dirty_m[wr_idx] <= 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rd_ok_q <= 1'b0;
    else rd_ok_q <= rd_en && (st_q == SScan || st_q == SFree ||
                              (st_q == SEvict && cnt_q < need_q));
  end

  assign tag_eq  = rd_used_q && (rd_dev_q == r_q.device);
  assign kind_eq = (rd_blk_q == r_q.block) &&
                   ((r_q.entry_type == 2'd0) || (r_q.op == dctt_pkg::OpInvEntry) ||
                    (rd_kind_q == r_q.entry_type));

  always_comb begin
    st_d = st_q; used_cnt_d = used_cnt_q; roll_d = roll_q; phase_d = phase_q;
    ptr_d = ptr_q; cnt_d = cnt_q; need_d = need_q; rsp_d = rsp_q; rv_d = rv_q;
    clr_used = 1'b0; set_dirty = 1'b0; clr_dirty = 1'b0; wr_tag = 1'b0;
    wr_idx = rd_idx_q;
    if (rv_q && rsp_ready_i) rv_d = 1'b0;
    case (st_q)
      SIdle: begin
        if (accept) begin
          ptr_d = '0; cnt_d = '0; rsp_d = '0;
          st_d  = SScan;
        end
      end
      SScan: begin
        if ((r_q.op != dctt_pkg::OpInvDev && r_q.op != dctt_pkg::OpFlush &&
             r_q.op != dctt_pkg::OpLookup && r_q.op != dctt_pkg::OpTouch &&
             r_q.op != dctt_pkg::OpInvEntry && r_q.op != dctt_pkg::OpDirty) ||
            (r_q.op != dctt_pkg::OpInvDev && r_q.op != dctt_pkg::OpFlush && !dev_ok)) begin
          if (r_q.op <= dctt_pkg::OpFlush) rsp_d.status = dctt_pkg::StBadDev;
          st_d = SOut;
        end else begin
          if (rd_en) ptr_d = ptr_q + 1'b1;
          if (rd_ok_q) begin
            case (r_q.op)
              dctt_pkg::OpInvDev: begin
                if (tag_eq) begin
                  clr_used = 1'b1; cnt_d = cnt_q + 1'b1;
                end
              end
              dctt_pkg::OpFlush: begin
                if (rd_used_q && rd_dirty_q) begin
                  clr_dirty = 1'b1; cnt_d = cnt_q + 1'b1;
                end
              end
              default: begin
                if (tag_eq && kind_eq) begin
                  rsp_d.hit = 1'b1; rsp_d.index = rd_idx_q;
                  if (r_q.op == dctt_pkg::OpDirty) set_dirty = 1'b1;
                  if (r_q.op == dctt_pkg::OpInvEntry) begin
                    clr_used = 1'b1; rsp_d.count = 7'd1;
                  end
                  st_d = SOut;
                end
              end
            endcase
          end
          if (st_d == SScan && !rd_en && !rd_ok_q) begin
            if (r_q.op == dctt_pkg::OpInvDev || r_q.op == dctt_pkg::OpFlush) begin
              rsp_d.count = cnt_q; st_d = SOut;
            end else if (r_q.op == dctt_pkg::OpTouch) begin
              phase_d = {2'b00, roll_q}; roll_d = roll_q + 1'b1;
              ptr_d = '0; st_d = SFree;
            end else st_d = SOut;
          end
        end
      end
      SFree: begin
        if (rd_en) ptr_d = ptr_q + 1'b1;
        if (rd_ok_q && !rd_used_q) begin
          wr_tag = 1'b1; rsp_d.allocated = 1'b1; rsp_d.index = rd_idx_q;
          st_d = SOut;
        end else if (!rd_en && !rd_ok_q) begin
          if (used_cnt_q < CW'(dctt_pkg::Entries / 2)) st_d = SGrow;
          else begin
            ptr_d = '0; cnt_d = '0;
            need_d = (used_cnt_q < CW'(dctt_pkg::EvictShare)) ? 7'd1 :
                     CW'((14'(used_cnt_q) * 14'd171) >> 9);
            st_d = SEvict;
          end
        end
      end
      SEvict: begin
        if (rd_en && cnt_q < need_q) ptr_d = ptr_q + 1'b1;
        if (rd_ok_q && cnt_q < need_q && rd_used_q && !rd_dirty_q &&
            ((rd_idx_q[1:0] + phase_q[1:0]) == 2'd0)) begin
          clr_used = 1'b1; cnt_d = cnt_q + 1'b1;
        end
        if ((!rd_en && !rd_ok_q) || (cnt_q >= need_q && !rd_ok_q)) begin
          phase_d = phase_q + 1'b1; ptr_d = '0;
          st_d = (phase_q + 1'b1 >= 4'(dctt_pkg::PhaseLimit)) ? SGrow : SFree;
        end
      end
      SGrow: begin
        if (used_cnt_q >= cap_eff) rsp_d.status = dctt_pkg::StFull;
        else begin
          wr_idx = used_cnt_q[IW-1:0]; wr_tag = 1'b1;
          used_cnt_d = used_cnt_q + 1'b1;
          rsp_d.allocated = 1'b1; rsp_d.index = used_cnt_q[IW-1:0];
        end
        st_d = SOut;
      end
      SOut: begin
        rv_d = 1'b1; st_d = SIdle;
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; used_cnt_q <= '0; roll_q <= '0; rv_q <= 1'b0;
    end else begin
      st_q <= st_d; used_cnt_q <= used_cnt_d; roll_q <= roll_d; rv_q <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) r_q <= req_i;
    phase_q <= phase_d; ptr_q <= ptr_d; cnt_q <= cnt_d; need_q <= need_d;
    rsp_q <= rsp_d;
  end

endmodule

// ----- rtl/dctt_checker.sv -----
`include "directory_cache_tag_table_unit_defines.svh"
module dctt_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           req_valid_i,
  input logic           req_ready_o,
  input logic           rsp_valid_o,
  input logic           rsp_ready_i,
  input dctt_pkg::rsp_t rsp_o
);
  `DCTT_ASSERT(a_busy_rsp, clk_i, rst_ni, !(rsp_valid_o && req_ready_o), "ready while word pending")
  `DCTT_ASSERT_NEXT(a_acc_busy, clk_i, rst_ni, req_valid_i && req_ready_o, !req_ready_o, "ready after accept")
  `DCTT_ASSERT(a_alloc_hit, clk_i, rst_ni, !(rsp_valid_o && rsp_o.hit && rsp_o.allocated), "hit and alloc")
  `DCTT_ASSERT_NEXT(a_hold, clk_i, rst_ni, rsp_valid_o && !rsp_ready_i, rsp_valid_o && $stable(rsp_o), "word dropped")
endmodule

bind directory_cache_tag_table_unit dctt_checker u_dctt_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .req_valid_i(req_valid_i), .req_ready_o(req_ready_o),
  .rsp_valid_o(rsp_valid_o), .rsp_ready_i(rsp_ready_i), .rsp_o(rsp_o)
);

// ----- bench/tag_table_checker.sv -----
module tag_table_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  input  logic           req_ready_i,
  input  dctt_pkg::req_t req_i,
  input  logic           rsp_valid_i,
  input  logic           rsp_ready_i,
  input  dctt_pkg::rsp_t rsp_i,
  input  logic           psel_i,
  input  logic           penable_i,
  input  logic           pwrite_i,
  input  logic           pready_i,
  input  logic [2:0]     paddr_i,
  input  logic [31:0]    pwdata_i,
  output int             fail_count_o,
  output int             pending_o
);
  import dctt_pkg::*;

  logic        tag_used  [Entries];
  logic        tag_dirty [Entries];
  logic [3:0]  tag_dev   [Entries];
  logic [31:0] tag_blk   [Entries];
  logic [1:0]  tag_kind  [Entries];
  int unsigned in_use;
  logic [1:0]  roll;
  logic [15:0] dev_mask;
  logic [6:0]  cap_reg;
  rsp_t        expected_rsp[$];

  function automatic int find_tag(logic [3:0] d, logic [31:0] b, logic [1:0] k);
    for (int i = 0; i < int'(in_use); i++)
      if (tag_used[i] && tag_dev[i] == d && tag_blk[i] == b && (k == 0 || tag_kind[i] == k))
        return i;
    return -1;
  endfunction

  function automatic int free_slot();
    for (int i = 0; i < int'(in_use); i++)
      if (!tag_used[i]) return i;
    return -1;
  endfunction

  function automatic int claim_slot();
    int unsigned phase;
    int unsigned limit;
    int unsigned need;
    int unsigned done;
    int slot;
    phase = roll;
    limit = (cap_reg < Entries) ? cap_reg : Entries;
    roll = roll + 2'd1;
    forever begin
      slot = free_slot();
      if (slot >= 0) return slot;
      if (in_use < Entries / 2) break;
      need = in_use / EvictShare;
      if (need == 0) need = 1;
      done = 0;
      for (int i = 0; i < int'(in_use) && done < need; i++)
        if (tag_used[i] && !tag_dirty[i] && ((i + phase) % 4) == 0) begin
          tag_used[i] = 1'b0;
          done++;
        end
      phase++;
      if (phase >= PhaseLimit) break;
    end
    if (in_use >= limit) return -1;
    slot = in_use;
    in_use++;
    return slot;
  endfunction

  function automatic rsp_t tag_table_step(req_t r);
    rsp_t o;
    int e;
    int unsigned cnt;
    o = '0;
    cnt = 0;
    case (r.op)
      OpLookup, OpTouch, OpDirty: begin
        if (!dev_mask[r.device]) begin
          o.status = StBadDev;
        end else begin
          e = find_tag(r.device, r.block, r.entry_type);
          if (e >= 0) begin
            o.hit = 1'b1;
            o.index = e[IdxW-1:0];
            if (r.op == OpDirty) tag_dirty[e] = 1'b1;
          end else if (r.op == OpTouch) begin
            e = claim_slot();
            if (e < 0) begin
              o.status = StFull;
            end else begin
              tag_used[e] = 1'b1;
              tag_dirty[e] = 1'b0;
              tag_dev[e] = r.device;
              tag_blk[e] = r.block;
              tag_kind[e] = r.entry_type;
              o.allocated = 1'b1;
              o.index = e[IdxW-1:0];
            end
          end
        end
      end
      OpInvDev: begin
        for (int i = 0; i < int'(in_use); i++)
          if (tag_used[i] && tag_dev[i] == r.device) begin
            tag_used[i] = 1'b0;
            cnt++;
          end
      end
      OpInvEntry: begin
        if (!dev_mask[r.device]) begin
          o.status = StBadDev;
        end else begin
          e = find_tag(r.device, r.block, 2'd0);
          if (e >= 0) begin
            tag_used[e] = 1'b0;
            o.hit = 1'b1;
            o.index = e[IdxW-1:0];
            cnt = 1;
          end
        end
      end
      OpFlush: begin
        for (int i = 0; i < int'(in_use); i++)
          if (tag_used[i] && tag_dirty[i]) begin
            tag_dirty[i] = 1'b0;
            cnt++;
          end
      end
      default: ;
    endcase
    if (cnt > 127) cnt = 127;
    o.count = cnt[CntW-1:0];
    return o;
  endfunction

  assign pending_o = expected_rsp.size();

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      in_use = 0;
      roll = '0;
      dev_mask = 16'hFFFF;
      cap_reg = 7'd64;
      fail_count_o <= 0;
      expected_rsp.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i == {RegMask, 2'b00}) dev_mask = pwdata_i[15:0];
        if (paddr_i == {RegCap, 2'b00}) cap_reg = pwdata_i[6:0];
      end
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_rsp.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected word %h", rsp_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_rsp.pop_front();
          if (want.hit !== rsp_i.hit || want.index !== rsp_i.index ||
              want.allocated !== rsp_i.allocated || want.status !== rsp_i.status ||
              want.count !== rsp_i.count) begin
            if (fail_count_o < 10)
              $display("mismatch: hit %0d/%0d index %0d/%0d alloc %0d/%0d status %0d/%0d count %0d/%0d",
                       want.hit, rsp_i.hit, want.index, rsp_i.index, want.allocated,
                       rsp_i.allocated, want.status, rsp_i.status, want.count, rsp_i.count);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (req_valid_i && req_ready_i) expected_rsp.push_back(tag_table_step(req_i));
    end
  end

endmodule

// ----- bench/testbench.sv -----
module testbench;
  import dctt_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        req_valid_i;
  logic        req_ready_o;
  req_t        req_i;
  logic        rsp_valid_o;
  logic        rsp_ready_i;
  rsp_t        rsp_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  bit          calm;
  bit          hold_go;
  int          hold_left;
  int          quiet_cycles;
  int          sent;

  directory_cache_tag_table_unit uut (.*);

  tag_table_checker checker_i (
    .clk_i, .rst_ni,
    .req_valid_i, .req_ready_i(req_ready_o), .req_i,
    .rsp_valid_i(rsp_valid_o), .rsp_ready_i, .rsp_i(rsp_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .pready_i(pready),
    .paddr_i(paddr), .pwdata_i(pwdata),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_ready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_go) begin
      hold_go = 1'b0;
      rsp_ready_i <= 1'b0;
      hold_left <= 3000;
    end else begin
      rsp_ready_i <= calm || ($urandom_range(0, 99) >= 34);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_valid_i && req_ready_o) || (rsp_valid_o && rsp_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 20000) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic reg_write(logic [0:0] which, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {which, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_word(req_t w);
    while (!calm && $urandom_range(0, 99) < 34) begin
      req_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i <= w;
    @(negedge clk_i);
    while (!req_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    sent++;
  endtask

  task automatic drain();
    req_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic send_op(logic [2:0] op, logic [3:0] dev, logic [31:0] blk, logic [1:0] k);
    req_t w;
    w.op = op;
    w.device = dev;
    w.block = blk;
    w.entry_type = k;
    send_word(w);
  endtask

  function automatic req_t random_word();
    req_t w;
    int pick;
    pick = $urandom_range(0, 99);
    w.device = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
    w.block = ($urandom_range(0, 9) == 0) ? $urandom : 32'h1000 + $urandom_range(0, 40);
    w.entry_type = 2'($urandom);
    if (pick < 40) w.op = OpTouch;
    else if (pick < 60) w.op = OpLookup;
    else if (pick < 72) w.op = OpDirty;
    else if (pick < 84) w.op = OpInvEntry;
    else if (pick < 89) w.op = OpInvDev;
    else if (pick < 95) w.op = OpFlush;
    else w.op = 3'($urandom_range(6, 7));
    return w;
  endfunction

  task automatic random_run(int n);
    for (int i = 0; i < n; i++) begin
      if (i == 100) calm = 1'b1;
      if (i == 180) calm = 1'b0;
      if (i == 50) hold_go = 1'b1;
      if (i == 200) drain();
      send_word(random_word());
    end
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    req_valid_i = 1'b0;
    req_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    calm = 1'b0;
    hold_go = 1'b0;
    hold_left = 0;
    sent = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_op(OpLookup, 4'd0, 32'd0, 2'd0);
    send_op(OpTouch, 4'd0, 32'd0, 2'd0);
    send_op(OpTouch, 4'd15, 32'hFFFF_FFFF, 2'd3);
    send_op(OpLookup, 4'd15, 32'hFFFF_FFFF, 2'd0);
    send_op(OpLookup, 4'd15, 32'hFFFF_FFFF, 2'd1);
    send_op(OpTouch, 4'd15, 32'hFFFF_FFFF, 2'd2);
    send_op(OpDirty, 4'd15, 32'hFFFF_FFFF, 2'd0);
    send_op(OpDirty, 4'd3, 32'h5555_AAAA, 2'd1);
    send_op(OpFlush, 4'd0, 32'd0, 2'd0);
    send_op(OpFlush, 4'd0, 32'd0, 2'd0);
    send_op(OpInvEntry, 4'd15, 32'hFFFF_FFFF, 2'd1);
    send_op(OpInvEntry, 4'd7, 32'h1234_5678, 2'd0);
    send_op(OpInvDev, 4'd0, 32'd0, 2'd0);
    send_op(OpInvDev, 4'd9, 32'd0, 2'd0);
    send_op(3'd6, 4'd15, 32'hFFFF_FFFF, 2'd3);
    send_op(3'd7, 4'd0, 32'd0, 2'd0);
    drain();
    reg_write(RegMask, 32'h0000_7FFF);
    send_op(OpTouch, 4'd15, 32'h1, 2'd1);
    send_op(OpLookup, 4'd15, 32'h1, 2'd0);
    send_op(OpDirty, 4'd15, 32'h1, 2'd0);
    send_op(OpInvEntry, 4'd15, 32'h1, 2'd0);
    send_op(OpInvDev, 4'd15, 32'h1, 2'd0);
    drain();
    reg_write(RegMask, 32'h0000_FFFF);

    random_run(300);
    reg_write(RegMask, 32'h0000_A5F7);
    reg_write(RegCap, 32'd20);
    random_run(150);
    reg_write(RegMask, 32'h0000_FFFF);
    reg_write(RegCap, 32'd0);
    random_run(60);
    reg_write(RegCap, 32'd127);
    random_run(200);
    reg_write(RegMask, 32'h0000_0000);
    reg_write(RegCap, 32'd1);
    random_run(30);
    reg_write(RegMask, 32'h0000_FFFF);
    reg_write(RegCap, 32'd64);
    random_run(110);

    repeat (1400) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/dctt_pkg.sv
rtl/directory_cache_tag_table_unit.sv
rtl/dctt_checker.sv
bench/tag_table_checker.sv
bench/testbench.sv
